// ----- src/msdeb_pkg.sv -----
// Shared constants and types for the multiplexed switch scan debouncer.
package msdeb_pkg;

  localparam int INPUTS_PER_MUX = 8;
  localparam int MUX_COUNT      = 2;
  localparam int ADDR_W         = $clog2(INPUTS_PER_MUX);
  localparam int MUX_W          = $clog2(MUX_COUNT);
  localparam int TIME_W         = 32;
  localparam int BOUNCE_W       = 16;

  localparam logic [BOUNCE_W-1:0] BOUNCE_RESET = BOUNCE_W'(50);
  localparam logic [ADDR_W-1:0]   ADDR_TOP     = ADDR_W'(INPUTS_PER_MUX - 1);

  localparam logic PH_DRIVE  = 1'b0;
  localparam logic PH_SAMPLE = 1'b1;

  typedef logic [INPUTS_PER_MUX-1:0] sw_vec_t;

  typedef struct packed {
    logic             en;
    logic [MUX_W-1:0] mux;
    sw_vec_t          fresh;
    logic [TIME_W-1:0] now;
  } deb_req_t;

endpackage

// ----- src/msdeb_bank.sv -----
// Per-switch lockout debounce: change times, debounced states, accept checks.
module msdeb_bank (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [msdeb_pkg::BOUNCE_W-1:0]   bounce_time_ms,
  input  msdeb_pkg::deb_req_t              req,
  output msdeb_pkg::sw_vec_t               state_next [msdeb_pkg::MUX_COUNT]
);
  import msdeb_pkg::*;

  logic [TIME_W-1:0] last_time [MUX_COUNT][INPUTS_PER_MUX];
  sw_vec_t           state     [MUX_COUNT];
  sw_vec_t           accept;

  always_comb begin
    logic [TIME_W-1:0] elapsed;
    sw_vec_t           diff;
    diff   = state[req.mux] ^ req.fresh;
    accept = '0;
    for (int k = 0; k < INPUTS_PER_MUX; k++) begin
      elapsed = req.now - last_time[req.mux][k];
      accept[k] = req.en && diff[k] &&
                  (elapsed >= {{(TIME_W-BOUNCE_W){1'b0}}, bounce_time_ms});
    end
    for (int m = 0; m < MUX_COUNT; m++) begin
      if (req.mux == MUX_W'(m)) begin
        state_next[m] = (state[m] & ~accept) | (req.fresh & accept);
      end else begin
        state_next[m] = state[m];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < MUX_COUNT; m++) begin
        state[m] <= '0;
        for (int k = 0; k < INPUTS_PER_MUX; k++) begin
          last_time[m][k] <= '0;
        end
      end
    end else begin
      for (int m = 0; m < MUX_COUNT; m++) begin
        state[m] <= state_next[m];
        for (int k = 0; k < INPUTS_PER_MUX; k++) begin
          if (req.mux == MUX_W'(m) && accept[k]) begin
            last_time[m][k] <= req.now;
          end
        end
      end
    end
  end

endmodule

// ----- src/mux_scanned_switch_debouncer_unit.sv -----
// Top level: two-multiplexer switch scanner with lockout debounce.
//
//  channel   dir  fields (tdata, low bit up)
//  s_axis    in   sample_bit[0], now_ms[32:1], zero pad[39:33]
//  m_axis    out  mux_address[2:0], mux_channel[3], mux_enable[4],
//                 board_switches[12:5], external_switches[20:13], pad[23:21]
//  cfg       in   bounce_time_ms write, taken whenever cfg_wr_en is high
//
// One item per cycle while the sink keeps up; each transfer's result lands in
// the output register in the next cycle. The input is taken while the output
// register is empty or being drained, so a stalled sink holds one result and
// back-pressures the source. rst is synchronous and returns the scan to the
// drive phase of multiplexer 0 at the top address, bounce time 50 ms.
module mux_scanned_switch_debouncer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // sample_bit, now_ms
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // mux_address, mux_channel, mux_enable,
                                     // board_switches, external_switches
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import msdeb_pkg::*;

  logic                scan_phase;
  logic [MUX_W-1:0]    current_mux;
  logic [ADDR_W-1:0]   current_address;
  sw_vec_t             sample_shift;
  sw_vec_t             sample_shift_next;
  logic [BOUNCE_W-1:0] bounce_time_ms;
  logic                in_fire;
  deb_req_t            req;
  sw_vec_t             state_next [MUX_COUNT];
  logic [23:0]         out_data_next;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign sample_shift_next = {sample_shift[INPUTS_PER_MUX-2:0], s_axis_tdata[0]};

  always_comb begin
    req.en    = in_fire && (scan_phase == PH_SAMPLE) && (current_address == '0);
    req.mux   = current_mux;
    req.fresh = sample_shift_next;
    req.now   = s_axis_tdata[32:1];
  end

  msdeb_bank u_bank (
    .clk            (clk),
    .rst            (rst),
    .bounce_time_ms (bounce_time_ms),
    .req            (req),
    .state_next     (state_next)
  );

  assign out_data_next = {3'b000, 8'(state_next[1]), 8'(state_next[0]),
                          (scan_phase == PH_DRIVE), 1'(current_mux),
                          3'(current_address)};

  always_ff @(posedge clk) begin
    if (rst) begin
      bounce_time_ms <= BOUNCE_RESET;
    end else if (cfg_wr_en) begin
      bounce_time_ms <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase      <= PH_DRIVE;
      current_mux     <= '0;
      current_address <= ADDR_TOP;
      sample_shift    <= '0;
    end else if (in_fire) begin
      if (scan_phase == PH_DRIVE) begin
        scan_phase <= PH_SAMPLE;
      end else begin
        scan_phase   <= PH_DRIVE;
        sample_shift <= sample_shift_next;
        if (current_address == '0) begin
          current_mux     <= current_mux + 1'b1;
          current_address <= ADDR_TOP;
        end else begin
          current_address <= current_address - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= out_data_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_toggle: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> scan_phase != $past(scan_phase))
    else $error("scan phase did not alternate on transfer");

  a_drive_enable: assert property (@(posedge clk) disable iff (rst)
    in_fire && scan_phase == PH_DRIVE |=> m_axis_tvalid && m_axis_tdata[4])
    else $error("drive step did not report enable");

  a_addr_hold_drive: assert property (@(posedge clk) disable iff (rst)
    in_fire && scan_phase == PH_DRIVE |=> $stable(current_address) && $stable(current_mux))
    else $error("address moved during drive phase");

  a_no_debounce_midscan: assert property (@(posedge clk) disable iff (rst)
    req.en |-> scan_phase == PH_SAMPLE && current_address == '0)
    else $error("debounce applied before full scan");
`endif

endmodule

// ----- bench/tb_mux_scanned_switch_debouncer_unit.sv -----
// Self-checking bench for the two-multiplexer switch scanner with lockout debounce.
module tb_mux_scanned_switch_debouncer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import msdeb_pkg::*;

  typedef struct packed {
    sw_vec_t           ext;
    sw_vec_t           brd;
    logic              en;
    logic [MUX_W-1:0]  ch;
    logic [ADDR_W-1:0] addr;
  } scan_out_t;

  typedef struct packed {
    logic              typed;
    logic              smp;
    logic [TIME_W-1:0] now;
    scan_out_t         want;
  } dir_row_t;

  localparam int        DIR_ROWS    = 24;
  localparam int        PHASES      = 5;
  localparam int        PHASE_ITEMS = 320;
  localparam int        GAP_MAX     = 17;
  localparam scan_out_t NO_WANT     = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // sample_bit, now_ms
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // mux_address, mux_channel, mux_enable,
                                   // board_switches, external_switches
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  mux_scanned_switch_debouncer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // Scan state mirror
  logic                  scan_ph;
  logic [MUX_W-1:0]      scan_mux;
  logic [ADDR_W-1:0]     scan_addr;
  sw_vec_t               sample_reg;
  sw_vec_t               switch_state [MUX_COUNT];
  logic [TIME_W-1:0]     accept_time [MUX_COUNT*INPUTS_PER_MUX];
  logic [BOUNCE_W-1:0]   lockout_ms;

  scan_out_t             scans_due [$];
  int                    err_count = 0;
  logic                  src_idle = 1'b1;
  logic                  snk_idle = 1'b1;
  logic [TIME_W-1:0]     clk_ms;
  logic [MUX_COUNT*INPUTS_PER_MUX-1:0] sw_level;

  // Mux 0 scans the pattern A5 and latches it at an elapsed time of FFFF_FFFF;
  // drive-phase sample bits are the inverse and must be ignored.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{1'b1, 1'b0, 32'h0000_0000, '{8'h00, 8'h00, 1'b1, 1'b0, 3'd7}},
    '{1'b0, 1'b1, 32'd1,         NO_WANT},
    '{1'b0, 1'b1, 32'd2,         NO_WANT},
    '{1'b0, 1'b0, 32'd3,         NO_WANT},
    '{1'b0, 1'b0, 32'd4,         NO_WANT},
    '{1'b0, 1'b1, 32'd5,         NO_WANT},
    '{1'b0, 1'b1, 32'd6,         NO_WANT},
    '{1'b0, 1'b0, 32'd7,         NO_WANT},
    '{1'b0, 1'b1, 32'd8,         NO_WANT},
    '{1'b0, 1'b0, 32'd9,         NO_WANT},
    '{1'b0, 1'b0, 32'd10,        NO_WANT},
    '{1'b0, 1'b1, 32'd11,        NO_WANT},
    '{1'b0, 1'b1, 32'd12,        NO_WANT},
    '{1'b0, 1'b0, 32'd13,        NO_WANT},
    '{1'b1, 1'b0, 32'h7FFF_FFFF, '{8'h00, 8'h00, 1'b1, 1'b0, 3'd0}},
    '{1'b1, 1'b1, 32'hFFFF_FFFF, '{8'h00, 8'hA5, 1'b0, 1'b0, 3'd0}},
    '{1'b1, 1'b1, 32'h0000_0000, '{8'h00, 8'hA5, 1'b1, 1'b1, 3'd7}},
    '{1'b0, 1'b1, 32'd40,        NO_WANT},
    '{1'b0, 1'b0, 32'd41,        NO_WANT},
    '{1'b0, 1'b0, 32'd49,        NO_WANT},
    '{1'b0, 1'b1, 32'd50,        NO_WANT},
    '{1'b0, 1'b1, 32'd51,        NO_WANT},
    '{1'b0, 1'b0, 32'h8000_0000, NO_WANT},
    '{1'b0, 1'b1, 32'hFFFF_FFFE, NO_WANT}
  };

  function automatic scan_out_t predict_scan_step(input logic smp,
                                                  input logic [TIME_W-1:0] now);
    scan_out_t         r;
    sw_vec_t           diff;
    sw_vec_t           accept;
    logic [TIME_W-1:0] elapsed;
    int                slot;
    r.addr = scan_addr;
    r.ch   = scan_mux;
    if (scan_ph == PH_DRIVE) begin
      scan_ph = PH_SAMPLE;
      r.en    = 1'b1;
    end else begin
      scan_ph    = PH_DRIVE;
      r.en       = 1'b0;
      sample_reg = {sample_reg[INPUTS_PER_MUX-2:0], smp};
      if (scan_addr == '0) begin
        diff   = switch_state[scan_mux] ^ sample_reg;
        accept = '0;
        for (int k = 0; k < INPUTS_PER_MUX; k++) begin
          slot    = scan_mux * INPUTS_PER_MUX + k;
          elapsed = now - accept_time[slot];
          if (diff[k] && elapsed >= TIME_W'(lockout_ms)) begin
            accept[k]         = 1'b1;
            accept_time[slot] = now;
          end
        end
        switch_state[scan_mux] = (switch_state[scan_mux] & ~accept) |
                                 (sample_reg & accept);
        scan_mux  = ~scan_mux;
        scan_addr = ADDR_TOP;
      end else begin
        scan_addr = scan_addr - 1'b1;
      end
    end
    r.brd = switch_state[0];
    r.ext = switch_state[1];
    return r;
  endfunction

  task automatic send_scan_item(input logic smp, input logic [TIME_W-1:0] now,
                                input logic typed, input scan_out_t want);
    int        gap;
    scan_out_t r;
    gap = src_idle ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, now, smp};
    do @(posedge clk); while (!s_axis_tready);
    r = predict_scan_step(smp, now);
    scans_due.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic send_random_item();
    int                pick;
    logic [TIME_W-1:0] now;
    logic              smp;
    int                idx;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      now = $urandom();
    end else begin
      if (pick < 12) clk_ms = clk_ms + $urandom_range(0, 70000);
      else clk_ms = clk_ms + $urandom_range(0, 3);
      now = clk_ms;
    end
    if ($urandom_range(0, 29) == 0) begin
      idx           = $urandom_range(0, MUX_COUNT*INPUTS_PER_MUX-1);
      sw_level[idx] = ~sw_level[idx];
    end
    smp = sw_level[{scan_mux, scan_addr}] ^ ($urandom_range(0, 7) == 0);
    send_scan_item(smp, now, 1'b0, NO_WANT);
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (scans_due.size() != 0);
  endtask

  task automatic set_bounce(input logic [BOUNCE_W-1:0] v);
    wait_for_drain();
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    lockout_ms   = v;
  endtask

  task automatic check_scan(input scan_out_t got);
    scan_out_t want;
    if (scans_due.size() == 0) begin
      err_count++;
      if (err_count <= 10) $display("unexpected scan result %h", got);
    end else begin
      want = scans_due.pop_front();
      if (got.addr !== want.addr || got.ch !== want.ch || got.en !== want.en ||
          got.brd !== want.brd || got.ext !== want.ext) begin
        err_count++;
        if (err_count <= 10)
          $display({"scan mismatch: exp addr %0d ch %0d en %0d brd %h ext %h,",
                    " got addr %0d ch %0d en %0d brd %h ext %h"},
                   want.addr, want.ch, want.en, want.brd, want.ext,
                   got.addr, got.ch, got.en, got.brd, got.ext);
      end
    end
  endtask

  initial begin
    logic [BOUNCE_W-1:0] plan [PHASES];
    plan = '{16'd0, 16'd65535, 16'd20, 16'd1, 16'd0};
    plan[PHASES-1] = BOUNCE_W'($urandom_range(2, 400));
    scan_ph   = PH_DRIVE;
    scan_mux  = '0;
    scan_addr = ADDR_TOP;
    sample_reg = '0;
    lockout_ms = BOUNCE_RESET;
    for (int m = 0; m < MUX_COUNT; m++) switch_state[m] = '0;
    for (int s = 0; s < MUX_COUNT*INPUTS_PER_MUX; s++) accept_time[s] = '0;
    sw_level = (MUX_COUNT*INPUTS_PER_MUX)'($urandom());
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIR_ROWS; i++)
      send_scan_item(dir_tab[i].smp, dir_tab[i].now, dir_tab[i].typed, dir_tab[i].want);
    for (int p = 0; p < PHASES; p++) begin
      set_bounce(plan[p]);
      clk_ms = (p % 2) ? 32'hFFFF_FE00 + $urandom_range(0, 255) : $urandom();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) src_idle = ($urandom_range(0, 3) != 0);
        if (i == PHASE_ITEMS/2) wait_for_drain();
        send_random_item();
      end
    end
    wait_for_drain();
    repeat (8) @(negedge clk);
    if (err_count == 0) begin
      $display("** mux_scanned_switch_debouncer_unit: PASSED **");
    end else begin
      $display("** mux_scanned_switch_debouncer_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    int gap;
    int n;
    n = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (n % 40 == 0) snk_idle = ($urandom_range(0, 3) != 0);
      gap = snk_idle ? $urandom_range(0, GAP_MAX) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      check_scan(m_axis_tdata[$bits(scan_out_t)-1:0]);
      n++;
      @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("** mux_scanned_switch_debouncer_unit: FAILED **");
    $finish;
  end

endmodule
